### sv/grid_ray_march_shader_defines.svh
// Assertion macros shared by the ray march checker.
// No dependencies; each macro expects aclk and aresetn in scope.
`ifndef GRID_RAY_MARCH_SHADER_DEFINES_SVH
`define GRID_RAY_MARCH_SHADER_DEFINES_SVH

// same-cycle implication
`define GRMS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("grms check failed");

// next-cycle implication
`define GRMS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("grms check failed");

`endif

### sv/grms_pkg.sv
// Types and constants for the grid ray march shader.
// No dependencies.
package grms_pkg;

    localparam int PX_W    = 20;
    localparam int ANG_W   = 12;
    localparam int LIGHT_W = 8;
    localparam int DIST_W  = 22;
    localparam int BR_W    = 9;
    localparam int CFG_AW  = 2;
    localparam int MUL_AW  = 28;
    localparam int MUL_BW  = 24;
    localparam int MUL_PW  = MUL_AW + MUL_BW;
    localparam int ACC_W   = MUL_PW + 1;

    localparam logic [CFG_AW-1:0] CFG_PLAYER_X    = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_PLAYER_Y    = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_VIEW_ANGLE  = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_LIGHT_LEVEL = 2'd3;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CAST  = 1'b1;

    localparam logic [PX_W-1:0]    PLAYER_RST = 20'd131072;
    localparam logic [ANG_W-1:0]   VIEW_RST   = 12'd1024;
    localparam logic [LIGHT_W-1:0] LIGHT_RST  = 8'd255;

    localparam logic [ANG_W-1:0] QUARTER_TURN = 12'd1024;
    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [16:0] SIN_C0    = 17'd5223;
    localparam logic [16:0] SIN_C1    = 17'd42334;
    localparam logic [16:0] SIN_C2    = 17'd102944;
    localparam logic [23:0] SIN_K     = 24'd307;
    localparam logic [BR_W-1:0] BR_BASE = 9'd150;
    localparam logic [7:0]  BR_MAX    = 8'd255;
    localparam logic [25:0] DIST_NEG_LIM = 26'd2097152;
    localparam logic [25:0] DIST_POS_LIM = 26'd2097151;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_TRIG  = 8'b0000_0100,
        ST_MARCH = 8'b0000_1000,
        ST_CALC  = 8'b0001_0000,
        ST_SQRT  = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

endpackage

### sv/grid_ray_march_shader.sv
// Grid ray march shader top level: wall map, march sequencer, shared multiplier.
// Depends on grms_pkg.
//
//  channel | ports                         | handshake
//  --------+-------------------------------+----------------------
//  config  | cfg_wr_en cfg_addr cfg_wdata  | write on cfg_wr_en
//  input   | s_valid s_ready s_*           | valid/ready
//  result  | m_valid m_ready m_*           | valid/ready
//
// After reset a clear pass writes all MAP_SIDE*MAP_SIDE map cells to empty, s_ready low.
// Write item: a map cell write. Cast item: sine ops for the x step, the y step and
// the view correction, one march sample per cycle (up to MAX_STEPS samples), then on
// a hit 12 multiplier ops, three square roots and a divide. The march length sets the pace.
// One item at a time: s_ready is low until the result item is taken.
module grid_ray_march_shader #(
    parameter int MAP_SIDE  = 16,
    parameter int MAX_STEPS = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [grms_pkg::CFG_AW-1:0]         cfg_addr,
    input  logic [grms_pkg::PX_W-1:0]           cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_action,
    input  logic [7:0]                          s_cell_index,
    input  logic                                s_cell_is_wall,
    input  logic [grms_pkg::ANG_W-1:0]          s_ray_angle,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_hit_found,
    output logic [grms_pkg::PX_W-1:0]           m_hit_x,
    output logic [grms_pkg::PX_W-1:0]           m_hit_y,
    output logic signed [grms_pkg::DIST_W-1:0]  m_corrected_distance,
    output logic [grms_pkg::BR_W-1:0]           m_brightness
);

    localparam int CELLS = MAP_SIDE * MAP_SIDE;
    localparam int CW    = $clog2(CELLS);
    localparam int CSW   = (MAP_SIDE > 16) ? $clog2(MAP_SIDE) : 4;
    localparam int XW    = CSW + 18;
    localparam int HW    = XW - 17;
    localparam int SW    = 2 * XW;
    localparam int NW    = $clog2(MAX_STEPS + 1);
    localparam int AW    = grms_pkg::ACC_W;

    grms_pkg::state_t state_reg, state_next;

    logic [grms_pkg::PX_W-1:0]    px_reg, py_reg;
    logic [grms_pkg::ANG_W-1:0]   view_reg;
    logic [grms_pkg::LIGHT_W-1:0] light_reg;

    logic [3:0]  op_reg, op_next;
    logic [1:0]  which_reg, which_next;
    logic [grms_pkg::ANG_W-1:0] ang_reg, ang_next;
    logic [15:0] t2_reg, t2_next;
    logic [16:0] p_reg, p_next;
    logic signed [11:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [16:0] cmag_reg, cmag_next;
    logic        cneg_reg, cneg_next;
    logic signed [XW-1:0] x_reg, x_next, y_reg, y_next;
    logic [NW-1:0] n_reg, n_next;
    logic        pend_reg, pend_next;
    logic        rd_reg;
    logic [AW-1:0] acc_reg, acc_next;
    logic [27:0] tmp_reg, tmp_next;
    logic [XW-1:0] dist_reg, dist_next, np_reg, np_next, nh_reg, nh_next;
    logic [SW-1:0] sqv_reg, sqv_next, sqr_reg, sqr_next, sqb_reg, sqb_next;
    logic [AW-1:0] rem_reg, rem_next, dsh_reg, dsh_next;
    logic [3:0]  dcnt_reg, dcnt_next;
    logic [7:0]  q_reg, q_next;
    logic [CW-1:0] clr_reg, clr_next;
    logic        hit_reg, hit_next;
    logic [grms_pkg::PX_W-1:0] hx_reg, hx_next, hy_reg, hy_next;
    logic [grms_pkg::DIST_W-1:0] cd_reg, cd_next;
    logic [grms_pkg::BR_W-1:0] br_reg, br_next;

    logic          mem [CELLS];
    logic          mem_we, mem_wd;
    logic [CW-1:0] mem_wa, mem_ra;

    logic [grms_pkg::MUL_AW-1:0] mul_a;
    logic [grms_pkg::MUL_BW-1:0] mul_b;
    logic [grms_pkg::MUL_PW-1:0] mul_p;

    // sine operand setup
    logic [grms_pkg::ANG_W-1:0] sang;
    logic [10:0] su;
    logic [15:0] st;
    logic [16:0] sprod_hi, smag;
    logic signed [11:0] sstep;
    logic        sneg;

    // march
    logic signed [XW-1:0] nx, ny;
    logic        n_out;

    // hit geometry
    logic signed [XW:0] dxs, dys;
    logic [XW:0]   adx, ady;
    logic [25:0]   cm;
    logic [SW-1:0] sq_sum, sqr_step;
    logic          sq_ge, d_ge;
    logic [AW-1:0] acc_sum;

    assign s_ready = (state_reg == grms_pkg::ST_IDLE);
    assign m_valid = (state_reg == grms_pkg::ST_DONE);
    assign m_hit_found = hit_reg;
    assign m_hit_x = hx_reg;
    assign m_hit_y = hy_reg;
    assign m_corrected_distance = $signed(cd_reg);
    assign m_brightness = br_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            px_reg    <= grms_pkg::PLAYER_RST;
            py_reg    <= grms_pkg::PLAYER_RST;
            view_reg  <= grms_pkg::VIEW_RST;
            light_reg <= grms_pkg::LIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                grms_pkg::CFG_PLAYER_X:    px_reg <= cfg_wdata;
                grms_pkg::CFG_PLAYER_Y:    py_reg <= cfg_wdata;
                grms_pkg::CFG_VIEW_ANGLE:  view_reg <= cfg_wdata[grms_pkg::ANG_W-1:0];
                grms_pkg::CFG_LIGHT_LEVEL: light_reg <= cfg_wdata[grms_pkg::LIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_reg <= mem[mem_ra];
    end

    always_comb begin
        case (which_reg)
            2'd0:    sang = ang_reg + grms_pkg::QUARTER_TURN;
            2'd1:    sang = ang_reg;
            default: sang = ang_reg - view_reg + grms_pkg::QUARTER_TURN;
        endcase
        su   = sang[10] ? (11'd1024 - {1'b0, sang[9:0]}) : {1'b0, sang[9:0]};
        st   = {su[9:0], 6'd0};
        sneg = sang[11];
    end

    assign nx = x_reg + {{(XW-12){sx_reg[11]}}, sx_reg};
    assign ny = y_reg + {{(XW-12){sy_reg[11]}}, sy_reg};
    assign n_out = nx[XW-1] || ny[XW-1] ||
                   (nx[XW-2:16] >= HW'(MAP_SIDE)) || (ny[XW-2:16] >= HW'(MAP_SIDE));
    assign mem_ra = CW'(32'(nx[XW-2:16]) + 32'(ny[XW-2:16]) * MAP_SIDE);

    assign dxs = $signed({x_reg[XW-1], x_reg}) - $signed({{(XW+1-grms_pkg::PX_W){1'b0}}, px_reg});
    assign dys = $signed({y_reg[XW-1], y_reg}) - $signed({{(XW+1-grms_pkg::PX_W){1'b0}}, py_reg});
    assign adx = dxs[XW] ? (~dxs + 1'b1) : dxs;
    assign ady = dys[XW] ? (~dys + 1'b1) : dys;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == grms_pkg::ST_TRIG) begin
            case (op_reg)
                4'd0:    begin mul_a = 28'(st);     mul_b = 24'(st);    end
                4'd1:    begin mul_a = 28'(t2_reg); mul_b = grms_pkg::SIN_K; end
                4'd2,
                4'd3:    begin mul_a = 28'(t2_reg); mul_b = 24'(p_reg); end
                default: begin mul_a = 28'(st);     mul_b = 24'(p_reg); end
            endcase
        end else begin
            case (op_reg)
                4'd0:    begin mul_a = 28'(adx);      mul_b = 24'(adx); end
                4'd1:    begin mul_a = 28'(ady);      mul_b = 24'(ady); end
                4'd2:    begin mul_a = 28'(px_reg);   mul_b = 24'(px_reg); end
                4'd3:    begin mul_a = 28'(py_reg);   mul_b = 24'(py_reg); end
                4'd4:    begin mul_a = 28'(x_reg);    mul_b = 24'(x_reg); end
                4'd5:    begin mul_a = 28'(y_reg);    mul_b = 24'(y_reg); end
                4'd6:    begin mul_a = 28'(cmag_reg); mul_b = 24'(dist_reg); end
                4'd7:    begin mul_a = 28'(px_reg);   mul_b = 24'(light_reg); end
                4'd8:    begin mul_a = tmp_reg;       mul_b = 24'(x_reg); end
                4'd9:    begin mul_a = 28'(py_reg);   mul_b = 24'(light_reg); end
                4'd10:   begin mul_a = tmp_reg;       mul_b = 24'(y_reg); end
                default: begin mul_a = 28'(np_reg);   mul_b = 24'(nh_reg); end
            endcase
        end
    end

    assign mul_p = mul_a * mul_b;

    assign sprod_hi = mul_p[32:16];
    assign smag  = su[10] ? grms_pkg::ONE_Q16 :
                   ((sprod_hi > grms_pkg::ONE_Q16) ? grms_pkg::ONE_Q16 : sprod_hi);
    assign sstep = sneg ? -$signed({1'b0, smag[16:6]}) : $signed({1'b0, smag[16:6]});

    assign cm       = mul_p[41:16];
    assign acc_sum  = acc_reg + AW'(mul_p);
    assign sq_sum   = sqr_reg + sqb_reg;
    assign sq_ge    = (sqv_reg >= sq_sum);
    assign sqr_step = sq_ge ? ((sqr_reg >> 1) + sqb_reg) : (sqr_reg >> 1);
    assign d_ge     = (rem_reg >= dsh_reg);

    function automatic logic [grms_pkg::BR_W-1:0] BR_W_SUM(input logic [7:0] v);
        return grms_pkg::BR_BASE + {1'b0, v};
    endfunction

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        which_next = which_reg;
        ang_next   = ang_reg;
        t2_next    = t2_reg;
        p_next     = p_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        cmag_next  = cmag_reg;
        cneg_next  = cneg_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        n_next     = n_reg;
        pend_next  = pend_reg;
        acc_next   = acc_reg;
        tmp_next   = tmp_reg;
        dist_next  = dist_reg;
        np_next    = np_reg;
        nh_next    = nh_reg;
        sqv_next   = sqv_reg;
        sqr_next   = sqr_reg;
        sqb_next   = sqb_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        dcnt_next  = dcnt_reg;
        q_next     = q_reg;
        clr_next   = clr_reg;
        hit_next   = hit_reg;
        hx_next    = hx_reg;
        hy_next    = hy_reg;
        cd_next    = cd_reg;
        br_next    = br_reg;
        mem_we     = 1'b0;
        mem_wa     = clr_reg;
        mem_wd     = 1'b0;

        case (state_reg)
            grms_pkg::ST_CLEAR: begin
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CW'(CELLS - 1)) begin
                    state_next = grms_pkg::ST_IDLE;
                end
            end
            grms_pkg::ST_IDLE: begin
                if (s_valid) begin
                    hit_next = 1'b0;
                    hx_next  = '0;
                    hy_next  = '0;
                    cd_next  = '0;
                    br_next  = '0;
                    if (s_action == grms_pkg::ACT_WRITE) begin
                        mem_we     = (32'(s_cell_index) < CELLS);
                        mem_wa     = CW'(s_cell_index);
                        mem_wd     = s_cell_is_wall;
                        state_next = grms_pkg::ST_DONE;
                    end else begin
                        ang_next   = s_ray_angle;
                        which_next = 2'd0;
                        op_next    = 4'd0;
                        state_next = grms_pkg::ST_TRIG;
                    end
                end
            end
            grms_pkg::ST_TRIG: begin
                op_next = op_reg + 1'b1;
                case (op_reg)
                    4'd0: t2_next = mul_p[31:16];
                    4'd1: p_next = grms_pkg::SIN_C0 - mul_p[32:16];
                    4'd2: p_next = grms_pkg::SIN_C1 - mul_p[32:16];
                    4'd3: p_next = grms_pkg::SIN_C2 - mul_p[32:16];
                    default: begin
                        op_next = 4'd0;
                        case (which_reg)
                            2'd0: sx_next = sstep;
                            2'd1: sy_next = sstep;
                            default: begin
                                cmag_next = smag;
                                cneg_next = sneg;
                            end
                        endcase
                        if (which_reg == 2'd2) begin
                            x_next     = XW'(px_reg);
                            y_next     = XW'(py_reg);
                            n_next     = '0;
                            pend_next  = 1'b0;
                            state_next = grms_pkg::ST_MARCH;
                        end else begin
                            which_next = which_reg + 1'b1;
                        end
                    end
                endcase
            end
            grms_pkg::ST_MARCH: begin
                // sample issued last cycle is tested against the map read here
                if (pend_reg && rd_reg) begin
                    op_next    = 4'd0;
                    state_next = grms_pkg::ST_CALC;
                end else if (n_reg == NW'(MAX_STEPS) || n_out) begin
                    state_next = grms_pkg::ST_DONE;
                end else begin
                    x_next    = nx;
                    y_next    = ny;
                    pend_next = 1'b1;
                    n_next    = n_reg + 1'b1;
                end
            end
            grms_pkg::ST_CALC: begin
                op_next = op_reg + 1'b1;
                case (op_reg)
                    4'd0, 4'd2, 4'd4, 4'd8: acc_next = AW'(mul_p);
                    4'd1, 4'd3, 4'd5: begin
                        acc_next   = acc_sum;
                        sqv_next   = acc_sum[SW-1:0];
                        sqr_next   = '0;
                        sqb_next   = SW'(1) << (SW - 2);
                        op_next    = op_reg;
                        state_next = grms_pkg::ST_SQRT;
                    end
                    4'd6: begin
                        if (cneg_reg) begin
                            cd_next = (cm >= grms_pkg::DIST_NEG_LIM) ? 22'h200000 :
                                      22'(26'd0 - cm);
                        end else begin
                            cd_next = (cm > grms_pkg::DIST_POS_LIM) ? 22'h1FFFFF : cm[21:0];
                        end
                    end
                    4'd7, 4'd9: tmp_next = mul_p[27:0];
                    4'd10: acc_next = acc_sum;
                    default: begin
                        hit_next = 1'b1;
                        hx_next  = x_reg[grms_pkg::PX_W-1:0];
                        hy_next  = y_reg[grms_pkg::PX_W-1:0];
                        if (mul_p == '0) begin
                            br_next    = grms_pkg::BR_BASE;
                            state_next = grms_pkg::ST_DONE;
                        end else begin
                            rem_next   = acc_reg;
                            dsh_next   = AW'(mul_p) << 8;
                            dcnt_next  = 4'd8;
                            q_next     = '0;
                            state_next = grms_pkg::ST_DIV;
                        end
                    end
                endcase
            end
            grms_pkg::ST_SQRT: begin
                if (sq_ge) begin
                    sqv_next = sqv_reg - sq_sum;
                end
                sqr_next = sqr_step;
                sqb_next = sqb_reg >> 2;
                if (sqb_reg[0]) begin
                    case (op_reg)
                        4'd1:    dist_next = sqr_step[XW-1:0];
                        4'd3:    np_next = sqr_step[XW-1:0];
                        default: nh_next = sqr_step[XW-1:0];
                    endcase
                    op_next    = op_reg + 1'b1;
                    state_next = grms_pkg::ST_CALC;
                end
            end
            grms_pkg::ST_DIV: begin
                if (d_ge) begin
                    rem_next = rem_reg - dsh_reg;
                end
                dsh_next  = dsh_reg >> 1;
                dcnt_next = dcnt_reg - 1'b1;
                q_next    = {q_reg[6:0], d_ge};
                if (dcnt_reg == 4'd8) begin
                    // quotient of 256 or more saturates
                    if (d_ge) begin
                        br_next    = BR_W_SUM(grms_pkg::BR_MAX);
                        state_next = grms_pkg::ST_DONE;
                    end
                end else if (dcnt_reg == 4'd0) begin
                    br_next    = BR_W_SUM(q_next);
                    state_next = grms_pkg::ST_DONE;
                end
            end
            grms_pkg::ST_DONE: begin
                if (m_ready) begin
                    state_next = grms_pkg::ST_IDLE;
                end
            end
            default: state_next = grms_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= grms_pkg::ST_CLEAR;
            clr_reg   <= '0;
            op_reg    <= '0;
            which_reg <= '0;
            pend_reg  <= 1'b0;
            n_reg     <= '0;
            dcnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            op_reg    <= op_next;
            which_reg <= which_next;
            pend_reg  <= pend_next;
            n_reg     <= n_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ang_reg  <= ang_next;
        t2_reg   <= t2_next;
        p_reg    <= p_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        cmag_reg <= cmag_next;
        cneg_reg <= cneg_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
        tmp_reg  <= tmp_next;
        dist_reg <= dist_next;
        np_reg   <= np_next;
        nh_reg   <= nh_next;
        sqv_reg  <= sqv_next;
        sqr_reg  <= sqr_next;
        sqb_reg  <= sqb_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        q_reg    <= q_next;
        hit_reg  <= hit_next;
        hx_reg   <= hx_next;
        hy_reg   <= hy_next;
        cd_reg   <= cd_next;
        br_reg   <= br_next;
    end

endmodule

### sv/grms_checker.sv
// Port-level checks for the grid ray march shader, bound to the top level.
// Depends on grms_pkg and grid_ray_march_shader_defines.svh.
`include "grid_ray_march_shader_defines.svh"

module grms_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic                                m_hit_found,
    input logic [grms_pkg::PX_W-1:0]           m_hit_x,
    input logic [grms_pkg::PX_W-1:0]           m_hit_y,
    input logic signed [grms_pkg::DIST_W-1:0]  m_corrected_distance,
    input logic [grms_pkg::BR_W-1:0]           m_brightness
);

    // one item in flight: never ready while a result waits
    `GRMS_ASSERT_NOW(a_one_item, m_valid, !s_ready)

    // a miss or a write carries all-zero fields
    `GRMS_ASSERT_NOW(a_miss_zero, m_valid && !m_hit_found, m_brightness == '0 && m_hit_x == '0 && m_hit_y == '0 && m_corrected_distance == '0)

    // a hit carries at least the base brightness and stays in range
    `GRMS_ASSERT_NOW(a_hit_bright, m_valid && m_hit_found, m_brightness >= grms_pkg::BR_BASE && m_brightness <= 9'd405)

    // stalled result holds
    `GRMS_ASSERT_NXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_brightness) && $stable(m_corrected_distance))

endmodule

bind grid_ray_march_shader grms_checker u_grms_checker (.*);
